[rtl/sssbu_pkg.sv]
// shared constants and register codes for the static scene background update block
package sssbu_pkg;

    localparam int FRAME_PIXELS = 65536;
    localparam int POS_W        = $clog2(FRAME_PIXELS);
    localparam int PIX_W        = 8;
    localparam int CNT_W        = 17;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 17;

    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_PIXELS - 1);
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_THRESHOLD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_COUNT_LIMIT = CFG_IDX_W'(1);

    // register reset values
    localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(16);
    localparam logic [CNT_W-1:0] LIMIT_RESET     = CNT_W'(655);

endpackage

[rtl/sssbu_ifs.sv]
// stream and configuration channel interfaces

interface sssbu_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [sssbu_pkg::PIX_W-1:0] pixel_gray;
    logic                        last_in_frame;

    modport source (output valid, output pixel_gray, output last_in_frame, input ready);
    modport sink   (input valid, input pixel_gray, input last_in_frame, output ready);
endinterface

interface sssbu_result_if;
    logic                        valid;
    logic                        ready;
    logic                        motion_bit;
    logic                        frame_done;
    logic [sssbu_pkg::CNT_W-1:0] moving_count;
    logic                        background_updated;
    logic                        background_valid;

    modport source (output valid, output motion_bit, output frame_done, output moving_count,
                    output background_updated, output background_valid, input ready);
    modport sink   (input valid, input motion_bit, input frame_done, input moving_count,
                    input background_updated, input background_valid, output ready);
endinterface

interface sssbu_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sssbu_pkg::CFG_IDX_W-1:0]  index;
    logic [sssbu_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/static_scene_background_update.sv]
// top level: frame differencing motion detector with double-buffered background
//
// pixel_in carries one grey pixel per transaction in raster order, with
// last_in_frame on the final pixel of each frame. result_out returns one
// transaction per pixel: the motion flag, the running moving-pixel count and,
// on the last pixel, whether the frame was static and became the background.
// cfg writes pixel_threshold (index 0) and static_count_limit (index 1); it is
// always ready and is meant to be used only while no pixel is in flight.
// the pixel and both bank reads are registered into the compare stage on the
// accepting edge; compare and count load the output register as that stage moves.
// throughput: one pixel per cycle while result_out is ready, set by the single
// write port of each frame bank; each bank write is forwarded to the compare of
// the pixel whose bank read happened on the same edge.
// reset clears the control state and restores the register defaults; the two
// frame banks are not cleared and hold nothing meaningful until the first frame
// has been written. there is no clearing pass.
// when result_out stalls the output register holds, the compare stage holds one
// more pixel behind it, and pixel_in drops ready until the output drains.
module static_scene_background_update (
    input  logic                  clk,
    input  logic                  rst_n,
    sssbu_pixel_if.sink           pixel_in,
    sssbu_result_if.source        result_out,
    sssbu_cfg_if.sink             cfg
);

    // configuration registers
    logic [sssbu_pkg::PIX_W-1:0] threshold_reg;
    logic [sssbu_pkg::CNT_W-1:0] limit_reg;

    // frame banks, one per buffer
    logic [sssbu_pkg::PIX_W-1:0] bank0_mem [sssbu_pkg::FRAME_PIXELS];
    logic [sssbu_pkg::PIX_W-1:0] bank1_mem [sssbu_pkg::FRAME_PIXELS];
    logic [sssbu_pkg::PIX_W-1:0] rd0_reg;
    logic [sssbu_pkg::PIX_W-1:0] rd1_reg;

    // accept stage: pixel position counter
    logic [sssbu_pkg::POS_W-1:0] pos_reg;
    logic [sssbu_pkg::POS_W-1:0] pos_next;

    // compare stage
    logic                        s1_valid_reg;
    logic [sssbu_pkg::PIX_W-1:0] s1_pix_reg;
    logic                        s1_last_reg;
    logic [sssbu_pkg::POS_W-1:0] s1_pos_reg;

    // frame state
    logic                        ref_sel_reg;
    logic                        ref_sel_next;
    logic                        have_prev_reg;
    logic                        have_prev_next;
    logic                        have_bg_reg;
    logic                        have_bg_next;
    logic [sssbu_pkg::CNT_W-1:0] cnt_reg;
    logic [sssbu_pkg::CNT_W-1:0] cnt_next;

    // last bank write, for the pixel that read the same entry on that edge
    logic                        fwd_valid_reg;
    logic                        fwd_bank_reg;
    logic [sssbu_pkg::POS_W-1:0] fwd_pos_reg;
    logic [sssbu_pkg::PIX_W-1:0] fwd_data_reg;

    // output register
    logic                        out_valid_reg;
    logic                        out_motion_reg;
    logic                        out_done_reg;
    logic [sssbu_pkg::CNT_W-1:0] out_count_reg;
    logic                        out_updated_reg;
    logic                        out_bg_valid_reg;

    logic                        in_fire;
    logic                        s1_fire;
    logic                        wr_bank;
    logic [sssbu_pkg::PIX_W-1:0] ref_pix;
    logic [sssbu_pkg::PIX_W-1:0] diff;
    logic                        motion;
    logic [sssbu_pkg::CNT_W-1:0] count_now;
    logic                        is_static;
    logic                        updated;

    // handshakes: compare stage moves when the output register is free or draining
    assign s1_fire         = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign pixel_in.ready  = !s1_valid_reg || s1_fire;
    assign in_fire         = pixel_in.valid && pixel_in.ready;
    assign cfg.ready       = 1'b1;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= sssbu_pkg::THRESHOLD_RESET;
            limit_reg     <= sssbu_pkg::LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                sssbu_pkg::REG_PIXEL_THRESHOLD:
                begin
                    threshold_reg <= cfg.data[sssbu_pkg::PIX_W-1:0];
                end
                sssbu_pkg::REG_STATIC_COUNT_LIMIT:
                begin
                    limit_reg <= cfg.data[sssbu_pkg::CNT_W-1:0];
                end
                default:
                begin
                    threshold_reg <= threshold_reg;
                end
            endcase
        end
    end

    // position advances at accept, wraps at the bank size, restarts after frame end
    always_comb
    begin
        if (pixel_in.last_in_frame || pos_reg == sssbu_pkg::POS_LAST)
            pos_next = '0;
        else
            pos_next = pos_reg + sssbu_pkg::POS_W'(1);
    end

    // both banks are read at accept; the bank choice is made in the compare stage,
    // after any swap from the previous frame's last pixel has settled
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd0_reg <= bank0_mem[pos_reg];
            rd1_reg <= bank1_mem[pos_reg];
        end
        if (s1_fire && !wr_bank)
            bank0_mem[s1_pos_reg] <= s1_pix_reg;
        if (s1_fire && wr_bank)
            bank1_mem[s1_pos_reg] <= s1_pix_reg;
    end

    // compare stage
    assign wr_bank = !ref_sel_reg;

    always_comb
    begin
        if (fwd_valid_reg && fwd_bank_reg == ref_sel_reg && fwd_pos_reg == s1_pos_reg)
            ref_pix = fwd_data_reg;
        else if (ref_sel_reg)
            ref_pix = rd1_reg;
        else
            ref_pix = rd0_reg;

        if (s1_pix_reg > ref_pix)
            diff = s1_pix_reg - ref_pix;
        else
            diff = ref_pix - s1_pix_reg;

        motion = have_prev_reg && (diff > threshold_reg);

        // saturating count, this pixel included
        if (motion && cnt_reg != sssbu_pkg::COUNT_MAX)
            count_now = cnt_reg + sssbu_pkg::CNT_W'(1);
        else
            count_now = cnt_reg;

        is_static = count_now <= limit_reg;

        ref_sel_next   = ref_sel_reg;
        have_prev_next = have_prev_reg;
        have_bg_next   = have_bg_reg;
        cnt_next       = count_now;
        updated        = 1'b0;

        if (s1_last_reg)
        begin
            cnt_next = '0;
            if (!have_prev_reg)
            begin
                // first frame only becomes the previous frame
                have_prev_next = 1'b1;
                ref_sel_next   = wr_bank;
            end
            else if (is_static)
            begin
                have_bg_next = 1'b1;
                updated      = 1'b1;
                ref_sel_next = wr_bank;
            end
            else if (!have_bg_reg)
            begin
                // moving frame still replaces the previous frame
                ref_sel_next = wr_bank;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            ref_sel_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            have_bg_reg   <= 1'b0;
            cnt_reg       <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                pos_reg <= pos_next;

            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                ref_sel_reg   <= ref_sel_next;
                have_prev_reg <= have_prev_next;
                have_bg_reg   <= have_bg_next;
                cnt_reg       <= cnt_next;
            end

            // forward only to a pixel whose bank read happened on the same edge,
            // and keep it while that pixel waits in the compare stage
            if (in_fire)
                fwd_valid_reg <= s1_fire;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg  <= pixel_in.pixel_gray;
            s1_last_reg <= pixel_in.last_in_frame;
            s1_pos_reg  <= pos_reg;
        end
        if (s1_fire)
        begin
            fwd_bank_reg     <= wr_bank;
            fwd_pos_reg      <= s1_pos_reg;
            fwd_data_reg     <= s1_pix_reg;
            out_motion_reg   <= motion;
            out_done_reg     <= s1_last_reg;
            out_count_reg    <= count_now;
            out_updated_reg  <= updated;
            out_bg_valid_reg <= have_bg_next;
        end
    end

    assign result_out.valid              = out_valid_reg;
    assign result_out.motion_bit         = out_motion_reg;
    assign result_out.frame_done         = out_done_reg;
    assign result_out.moving_count       = out_count_reg;
    assign result_out.background_updated = out_updated_reg;
    assign result_out.background_valid   = out_bg_valid_reg;

    // count restarts after every frame end
    a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> cnt_reg == '0)
        else $error("motion count not cleared after frame end");

    // once a background exists it is never lost
    a_bg_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        have_bg_reg |=> have_bg_reg)
        else $error("background valid dropped");

    // no motion can be flagged before a reference frame exists
    a_no_motion_first: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !have_prev_reg |-> !motion)
        else $error("motion flagged without a reference frame");

    // an accepted pixel always lands in the compare stage
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted pixel lost before compare stage");

endmodule

[dv/static_scene_background_update_test.sv]
// self-checking testbench for the static scene background update block
module static_scene_background_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    // number of registers in the map; indexes from here up are ignored by the block
    localparam int unsigned REG_COUNT     = 2;
    localparam int unsigned RANDOM_ITEMS  = 450;
    localparam int unsigned HOLD_CYCLES   = 120;
    localparam int unsigned MAX_SHOWN     = 40;
    // longest frame of the run; the two opening frames write every position up to it
    localparam int unsigned FRAME_LEN_MAX = 400;

    // one result transaction, field for field
    typedef struct packed {
        logic                        motion_bit;
        logic                        frame_done;
        logic [sssbu_pkg::CNT_W-1:0] moving_count;
        logic                        background_updated;
        logic                        background_valid;
    } scene_result_t;

    // how the pixels of a generated frame relate to the scene seen so far
    typedef enum int {
        FRAME_DARK,
        FRAME_BRIGHT,
        FRAME_BUSY,
        FRAME_STILL,
        FRAME_PATCHY
    } frame_style_t;

    // motion predictor plus the queue of results it is waiting for
    class scene_scoreboard;
        bit [sssbu_pkg::PIX_W-1:0]  bank_mem [2][sssbu_pkg::FRAME_PIXELS];
        bit                         ref_sel;
        bit [sssbu_pkg::POS_W-1:0]  pos_q;
        bit [sssbu_pkg::CNT_W-1:0]  motion_cnt;
        bit                         seen_frame;
        bit                         have_bg;
        bit [sssbu_pkg::PIX_W-1:0]  thr;
        bit [sssbu_pkg::CNT_W-1:0]  limit;
        scene_result_t              awaited[$];
        int unsigned                errors;
        int unsigned                results_seen;
        int unsigned                pixels;
        int unsigned                frames;
        int unsigned                static_frames;
        int unsigned                reg_writes;

        function new();
            thr   = sssbu_pkg::THRESHOLD_RESET;
            limit = sssbu_pkg::LIMIT_RESET;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void note_config(input bit [sssbu_pkg::CFG_IDX_W-1:0] idx,
                                  input bit [sssbu_pkg::CFG_DATA_W-1:0] value);
            reg_writes++;
            if (idx == sssbu_pkg::REG_PIXEL_THRESHOLD)
                thr = value[sssbu_pkg::PIX_W-1:0];
            else if (idx == sssbu_pkg::REG_STATIC_COUNT_LIMIT)
                limit = value[sssbu_pkg::CNT_W-1:0];
        endfunction

        function void note_pixel(input bit [sssbu_pkg::PIX_W-1:0] gray, input bit last);
            bit                        wr_sel;
            bit [sssbu_pkg::PIX_W-1:0] ref_pix;
            bit [sssbu_pkg::PIX_W-1:0] diff;
            scene_result_t             want;
            wr_sel = ~ref_sel;
            want   = '0;
            pixels++;
            if (seen_frame)
            begin
                ref_pix = bank_mem[ref_sel][pos_q];
                diff    = (gray > ref_pix) ? gray - ref_pix : ref_pix - gray;
                if (diff > thr)
                begin
                    want.motion_bit = 1'b1;
                    if (motion_cnt != sssbu_pkg::COUNT_MAX)
                        motion_cnt++;
                end
            end
            bank_mem[wr_sel][pos_q] = gray;
            want.frame_done   = last;
            want.moving_count = motion_cnt;
            if (last)
            begin
                frames++;
                if (!seen_frame)
                begin
                    seen_frame = 1'b1;
                    ref_sel    = wr_sel;
                end
                else if (motion_cnt <= limit)
                begin
                    have_bg                 = 1'b1;
                    want.background_updated = 1'b1;
                    ref_sel                 = wr_sel;
                    static_frames++;
                end
                else if (!have_bg)
                begin
                    ref_sel = wr_sel;
                end
                motion_cnt = '0;
                pos_q      = '0;
            end
            else
            begin
                pos_q++;
            end
            want.background_valid = have_bg;
            awaited.push_back(want);
        endfunction

        task check_result(input scene_result_t got);
            scene_result_t want;
            results_seen++;
            if (awaited.size() == 0)
            begin
                report($sformatf("result %0d arrived with no pixel outstanding", results_seen));
            end
            else
            begin
                want = awaited.pop_front();
                if (got.motion_bit !== want.motion_bit)
                    report($sformatf("result %0d motion_bit got %b want %b",
                                     results_seen, got.motion_bit, want.motion_bit));
                if (got.frame_done !== want.frame_done)
                    report($sformatf("result %0d frame_done got %b want %b",
                                     results_seen, got.frame_done, want.frame_done));
                if (got.moving_count !== want.moving_count)
                    report($sformatf("result %0d moving_count got %0d want %0d",
                                     results_seen, got.moving_count, want.moving_count));
                if (got.background_updated !== want.background_updated)
                    report($sformatf("result %0d background_updated got %b want %b",
                                     results_seen, got.background_updated,
                                     want.background_updated));
                if (got.background_valid !== want.background_valid)
                    report($sformatf("result %0d background_valid got %b want %b",
                                     results_seen, got.background_valid,
                                     want.background_valid));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    sssbu_pixel_if  pix_if();
    sssbu_result_if res_if();
    sssbu_cfg_if    cfg_if();

    static_scene_background_update dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pix_if),
        .result_out (res_if),
        .cfg        (cfg_if)
    );

    scene_scoreboard book;

    // generator side view of the scene, used to build frames close to what the
    // block holds so that static frames actually happen
    bit [sssbu_pkg::PIX_W-1:0] scene_img [sssbu_pkg::FRAME_PIXELS];
    bit [sssbu_pkg::PIX_W-1:0] cur_thr;
    int unsigned               idle_pct;        // chance in percent of an idle burst, both sides
    int unsigned               hold_requests;   // bumped by the sender, served by the result side
    int unsigned               pixels_sent;

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop, far above the slowest legal run
    initial
    begin
        #50_000_000;
        $display("static_scene_background_update_test failed");
        $finish;
    end

    // result side: random ready bursts, plus one long hold on request
    initial
    begin
        int unsigned gap_left;
        int unsigned hold_left;
        int unsigned holds_seen;
        gap_left     = 0;
        hold_left    = 0;
        holds_seen   = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                // long hold-off so the block fills and backs up its input
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left != 0)
            begin
                res_if.ready <= 1'b0;
                gap_left--;
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                res_if.ready <= 1'b0;
                gap_left = $urandom_range(1, 14) - 1;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // result monitor: sample at the falling edge, the transaction lands on the next rising one
    initial
    begin
        scene_result_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            begin
                got.motion_bit         = res_if.motion_bit;
                got.frame_done         = res_if.frame_done;
                got.moving_count       = res_if.moving_count;
                got.background_updated = res_if.background_updated;
                got.background_valid   = res_if.background_valid;
                book.check_result(got);
            end
        end
    end

    // one register write; valid is left high so back-to-back writes need no lowering
    task automatic write_reg(input bit [sssbu_pkg::CFG_IDX_W-1:0] idx,
                             input bit [sssbu_pkg::CFG_DATA_W-1:0] value);
        bit took;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
        begin
            @(negedge clk);
            took = (cfg_if.ready === 1'b1);
            if (took)
                book.note_config(idx, value);
            @(posedge clk);
        end
        while (!took);
        if (idx == sssbu_pkg::REG_PIXEL_THRESHOLD)
            cur_thr = value[sssbu_pkg::PIX_W-1:0];
    endtask

    // one pixel transaction, with an optional idle burst in front of it
    task automatic send_pixel(input bit [sssbu_pkg::PIX_W-1:0] gray, input bit last);
        bit took;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        pix_if.valid         <= 1'b1;
        pix_if.pixel_gray    <= gray;
        pix_if.last_in_frame <= last;
        do
        begin
            @(negedge clk);
            took = (pix_if.ready === 1'b1);
            if (took)
                book.note_pixel(gray, last);
            @(posedge clk);
        end
        while (!took);
        pixels_sent++;
    endtask

    task automatic send_four(input bit [sssbu_pkg::PIX_W-1:0] p0,
                             input bit [sssbu_pkg::PIX_W-1:0] p1,
                             input bit [sssbu_pkg::PIX_W-1:0] p2,
                             input bit [sssbu_pkg::PIX_W-1:0] p3);
        send_pixel(p0, 1'b0);
        send_pixel(p1, 1'b0);
        send_pixel(p2, 1'b0);
        send_pixel(p3, 1'b1);
    endtask

    // wait for every outstanding result, then let the pipeline settle
    task automatic wait_drained(input int unsigned max_cycles);
        int unsigned n;
        n = 0;
        while (book.pending() != 0 && n < max_cycles)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
    endtask

    // a whole frame; pause_at >= 0 stops the sender mid-frame until the block drains
    task automatic send_frame(input int unsigned len, input frame_style_t style,
                              input int pause_at);
        int unsigned               pos;
        int                        amp;
        int                        v;
        bit [sssbu_pkg::PIX_W-1:0] gray;
        for (int unsigned i = 0; i < len; i++)
        begin
            pos = i % sssbu_pkg::FRAME_PIXELS;
            if (int'(i) == pause_at)
            begin
                pix_if.valid <= 1'b0;
                wait_drained(1_000_000);
            end
            case (style)
                FRAME_DARK:   gray = sssbu_pkg::PIX_W'($urandom_range(60));
                FRAME_BRIGHT: gray = sssbu_pkg::PIX_W'($urandom_range(200, 255));
                FRAME_BUSY:   gray = sssbu_pkg::PIX_W'($urandom_range(255));
                default:
                begin
                    if (style == FRAME_PATCHY && $urandom_range(7) == 0)
                    begin
                        gray = sssbu_pkg::PIX_W'($urandom_range(255));
                    end
                    else
                    begin
                        // jitter around the scene, reaching just past the threshold
                        amp = int'(cur_thr) + 1;
                        v   = int'(scene_img[pos]) + int'($urandom_range(2 * amp)) - amp;
                        if (v < 0)
                            v = 0;
                        if (v > 255)
                            v = 255;
                        gray = v[sssbu_pkg::PIX_W-1:0];
                    end
                end
            endcase
            send_pixel(gray, i == len - 1);
            scene_img[pos] = gray;
        end
    endtask

    // a random mix of register writes, extremes included, some ignored by index
    task automatic random_config();
        bit [sssbu_pkg::PIX_W-1:0] thr_val;
        bit [sssbu_pkg::CNT_W-1:0] lim_val;
        case ($urandom_range(9))
            0:       thr_val = '0;
            1:       thr_val = '1;
            2, 3:    thr_val = sssbu_pkg::PIX_W'($urandom_range(255));
            default: thr_val = sssbu_pkg::PIX_W'($urandom_range(4, 40));
        endcase
        case ($urandom_range(9))
            0:       lim_val = '0;
            1:       lim_val = sssbu_pkg::CNT_W'(65536);
            2:       lim_val = sssbu_pkg::COUNT_MAX;
            3, 4, 5: lim_val = sssbu_pkg::CNT_W'($urandom_range(8));
            default: lim_val = sssbu_pkg::CNT_W'($urandom_range(60));
        endcase
        if ($urandom_range(3) != 0)
            write_reg(sssbu_pkg::REG_PIXEL_THRESHOLD,
                      {(sssbu_pkg::CFG_DATA_W - sssbu_pkg::PIX_W)'($urandom), thr_val});
        if ($urandom_range(3) != 0)
            write_reg(sssbu_pkg::REG_STATIC_COUNT_LIMIT, lim_val);
        if ($urandom_range(7) == 0)
            write_reg(sssbu_pkg::CFG_IDX_W'($urandom_range(REG_COUNT,
                                                           2 ** sssbu_pkg::CFG_IDX_W - 1)),
                      sssbu_pkg::CFG_DATA_W'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        int unsigned  random_start;
        int unsigned  phase_no;
        int unsigned  frames_in_phase;
        int unsigned  len;
        int unsigned  pick;
        int           pause_at;
        frame_style_t style;

        book          = new();
        cur_thr       = sssbu_pkg::THRESHOLD_RESET;
        idle_pct      = 0;
        hold_requests = 0;
        pixels_sent   = 0;

        // every input known from time zero
        rst_n                = 1'b0;
        pix_if.valid         = 1'b0;
        pix_if.pixel_gray    = '0;
        pix_if.last_in_frame = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // an out of range index must leave both registers at their defaults
        write_reg(sssbu_pkg::CFG_IDX_W'(REG_COUNT), '1);
        cfg_if.valid <= 1'b0;

        // first frame has no reference and fills one bank over every position used later
        idle_pct = 3;
        send_frame(FRAME_LEN_MAX, FRAME_DARK, -1);
        pix_if.valid <= 1'b0;
        wait_drained(1_000_000);

        // limit 0 so any motion makes a frame moving;
        // threshold written with junk in the unused upper bits
        write_reg(sssbu_pkg::REG_PIXEL_THRESHOLD, {9'h1a5, 8'd16});
        write_reg(sssbu_pkg::REG_STATIC_COUNT_LIMIT, '0);
        cfg_if.valid <= 1'b0;

        // every pixel moving: becomes the previous frame and fills the other bank
        send_frame(FRAME_LEN_MAX, FRAME_BRIGHT, -1);

        // directed short frames
        idle_pct = 20;
        send_four(8'd0, 8'd255, 8'd100, 8'd100);   // moving against previous, no background yet
        send_four(8'd0, 8'd255, 8'd100, 8'd100);   // identical, becomes the first background
        send_four(8'd16, 8'd239, 8'd117, 8'd83);   // diffs of exactly threshold and one above
        send_four(8'd0, 8'd255, 8'd100, 8'd100);   // back to the background, static again
        send_pixel(8'd255, 1'b1);                   // one pixel frame, moving, background kept
        pix_if.valid <= 1'b0;
        wait_drained(1_000_000);

        // threshold at zero, limit at the frame size (65536)
        write_reg(sssbu_pkg::REG_PIXEL_THRESHOLD, '0);
        write_reg(sssbu_pkg::REG_STATIC_COUNT_LIMIT, sssbu_pkg::CFG_DATA_W'(65536));
        cfg_if.valid <= 1'b0;
        send_four(8'd0, 8'd255, 8'd101, 8'd100);
        pix_if.valid <= 1'b0;
        wait_drained(1_000_000);

        // threshold at full scale, nothing can move
        write_reg(sssbu_pkg::REG_PIXEL_THRESHOLD, '1);
        write_reg(sssbu_pkg::REG_STATIC_COUNT_LIMIT, '0);
        cfg_if.valid <= 1'b0;
        send_four(8'd255, 8'd0, 8'd0, 8'd255);
        pix_if.valid <= 1'b0;
        wait_drained(1_000_000);

        // random phases: new settings while idle, then a handful of frames;
        // the stall phases always run
        random_start = pixels_sent;
        phase_no     = 0;
        while (pixels_sent - random_start < RANDOM_ITEMS || phase_no < 3)
        begin
            wait_drained(1_000_000);
            random_config();
            // the tail of the run goes with no idling at all
            if (pixels_sent - random_start + 300 > RANDOM_ITEMS)
                idle_pct = 0;
            else if ($urandom_range(3) == 0)
                idle_pct = 0;
            else
                idle_pct = $urandom_range(5, 40);
            frames_in_phase = $urandom_range(1, 6);
            for (int unsigned k = 0; k < frames_in_phase; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    len = $urandom_range(1, 24);
                else if (pick < 95)
                    len = $urandom_range(25, 120);
                else
                    len = $urandom_range(121, FRAME_LEN_MAX);
                pick = $urandom_range(9);
                if (pick < 2)
                    style = FRAME_BUSY;
                else if (pick < 6)
                    style = FRAME_STILL;
                else
                    style = FRAME_PATCHY;
                pause_at = -1;
                if (phase_no == 1 && k == 0)
                begin
                    // result side stalls for a long stretch while pixels keep coming
                    idle_pct = 0;
                    len      = 60;
                    hold_requests++;
                end
                if (phase_no == 2 && k == 0)
                begin
                    // sender stops mid-frame until every result is back
                    len      = 40;
                    pause_at = 17;
                end
                send_frame(len, style, pause_at);
            end
            pix_if.valid <= 1'b0;
            phase_no++;
        end

        // all stimulus accepted: let the pipeline empty out
        wait_drained(100_000);
        if (book.pending() != 0)
            book.report($sformatf("%0d results never arrived", book.pending()));
        repeat (8) @(posedge clk);

        $display("run covered %0d pixels in %0d frames, %0d of them static",
                 book.pixels, book.frames, book.static_frames);
        $display("%0d register writes over %0d random phases, %0d results checked, %0d errors",
                 book.reg_writes, phase_no, book.results_seen, book.errors);
        if (book.errors == 0)
            $display("static_scene_background_update_test passed");
        else
            $display("static_scene_background_update_test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/sssbu_pkg.sv
rtl/sssbu_ifs.sv
rtl/static_scene_background_update.sv
dv/static_scene_background_update_test.sv
